// ===== src/isaac_random_generator_defines.svh =====
// Assertion helpers for the ISAAC generator
`ifndef ISAAC_RANDOM_GENERATOR_DEFINES_SVH
`define ISAAC_RANDOM_GENERATOR_DEFINES_SVH

// property checked at every clock edge outside reset
`define ISAAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent implies consequent on the following edge
`define ISAAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/isaac_pkg.sv =====
package isaac_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_INIT = 2'd1,
    OP_NEXT = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MX_IDLE = 2'd0,
    MX_GOLD = 2'd1,
    MX_STEP = 2'd2,
    MX_ADD  = 2'd3
  } mix_op_t;

  typedef struct packed {
    mix_op_t     op;
    logic [2:0]  k;
    logic [31:0] val;
  } mix_cmd_t;

  typedef logic [7:0][31:0] word8_t;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  // shift amount of each mix step; even steps shift left, odd steps right
  localparam logic [4:0] MIX_SHIFT [8] = '{5'd11, 5'd2, 5'd8, 5'd16,
                                           5'd10, 5'd4, 5'd8, 5'd9};

endpackage

// ===== src/isaac_mix.sv =====
module isaac_mix (
  input  logic               clk,
  input  isaac_pkg::mix_cmd_t cmd,
  output isaac_pkg::word8_t  v
);
  import isaac_pkg::*;

  word8_t      v_next;
  logic [2:0]  k1, k2, k3;
  logic [31:0] sh, t;

  always_comb begin
    k1 = cmd.k + 3'd1;
    k2 = cmd.k + 3'd2;
    k3 = cmd.k + 3'd3;
    sh = cmd.k[0] ? (v[k1] >> MIX_SHIFT[cmd.k]) : (v[k1] << MIX_SHIFT[cmd.k]);
    t  = v[cmd.k] ^ sh;
    v_next = v;
    unique case (cmd.op)
      MX_GOLD: begin
        for (int i = 0; i < 8; i++) v_next[i] = GOLDEN;
      end
      MX_STEP: begin
        v_next[cmd.k] = t;
        v_next[k3]    = v[k3] + t;
        v_next[k1]    = v[k1] + v[k2];
      end
      MX_ADD:  v_next[cmd.k] = v[cmd.k] + cmd.val;
      MX_IDLE: v_next = v;
    endcase
  end

  always_ff @(posedge clk) begin
    v <= v_next;
  end

endmodule

// ===== src/isaac_random_generator.sv =====
// ISAAC 32-bit generator with a 2**SIZE_LOG2 word state memory and result buffer.
// A load item writes the result buffer directly from idle. A next item reads a
// buffered word and delivers it to the output register; when the buffer is empty
// it first runs a generation round, paced by the single read port of the state
// memory (four dependent reads per word, each followed by its registered data,
// plus one write of the new state word). An initialize item premixes the golden
// ratio words in four passes of the eight mix steps, mixes each block of eight
// words (two passes in seed mode), then runs one round.
// The mixing is done by one shared unit, one of eight mix steps per cycle.
// No clearing pass follows reset.
`include "isaac_random_generator_defines.svh"
module isaac_random_generator #(
  parameter int SIZE_LOG2 = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  seed_index,
  input  logic [31:0] seed_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import isaac_pkg::*;

  localparam int SIZE = 1 << SIZE_LOG2;
  localparam logic [SIZE_LOG2-1:0] LAST_BLK = SIZE_LOG2'(SIZE - 8);
  localparam logic [SIZE_LOG2-1:0] LAST_IDX = SIZE_LOG2'(SIZE - 1);
  localparam logic [SIZE_LOG2-1:0] HALF     = SIZE_LOG2'(SIZE / 2);
  localparam logic [SIZE_LOG2:0]   FULL     = (SIZE_LOG2 + 1)'(SIZE);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_I_START = 14'b00000000000010,
    S_I_PRE   = 14'b00000000000100,
    S_I_ADD   = 14'b00000000001000,
    S_I_MIX   = 14'b00000000010000,
    S_I_WR    = 14'b00000000100000,
    S_G_START = 14'b00000001000000,
    S_G_X     = 14'b00000010000000,
    S_G_J     = 14'b00000100000000,
    S_G_Y     = 14'b00001000000000,
    S_G_R     = 14'b00010000000000,
    S_G_B     = 14'b00100000000000,
    S_N_RD    = 14'b01000000000000,
    S_N_OUT   = 14'b10000000000000
  } state_t;

  state_t state;

  logic                 seed_mode;
  logic [31:0]          accum_a, accum_b, round_counter;
  logic [SIZE_LOG2:0]   words_left;
  logic [SIZE_LOG2-1:0] idx;
  logic [3:0]           sub;
  logic [1:0]           rep;
  logic                 pass2;
  logic                 from_next;
  logic [31:0]          x, y;

  logic [31:0]          sm [SIZE];
  logic [31:0]          sm_q;
  logic [SIZE_LOG2-1:0] sm_raddr, sm_waddr;
  logic                 sm_we;
  logic [31:0]          sm_wdata;

  logic [31:0]          rb [SIZE];
  logic [SIZE-1:0]      rb_valid;
  logic [31:0]          rb_q;
  logic                 rb_qv;
  logic [SIZE_LOG2-1:0] rb_raddr, rb_waddr;
  logic                 rb_we;
  logic [31:0]          rb_wdata, rb_data;

  mix_cmd_t             mcmd;
  word8_t               v;

  logic                 in_accept;
  logic [31:0]          mv, a_upd, y_new, b_new, rc_inc;
  logic [SIZE_LOG2-1:0] sub_addr;

  isaac_mix u_mix (.clk(clk), .cmd(mcmd), .v(v));

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign rb_data   = rb_qv ? rb_q : 32'd0;
  assign sub_addr  = idx + SIZE_LOG2'(sub[2:0]);

  always_comb begin
    unique case (idx[1:0])
      2'd0: mv = accum_a << 13;
      2'd1: mv = accum_a >> 6;
      2'd2: mv = accum_a << 2;
      2'd3: mv = accum_a >> 16;
    endcase
    a_upd  = (accum_a ^ mv) + sm_q;
    y_new  = sm_q + accum_a + accum_b;
    b_new  = sm_q + x;
    rc_inc = round_counter + 32'd1;
  end

  // memory ports and mix unit commands
  always_comb begin
    sm_raddr = idx;
    sm_we    = 1'b0;
    sm_waddr = idx;
    sm_wdata = y_new;
    rb_raddr = words_left[SIZE_LOG2-1:0];
    rb_we    = 1'b0;
    rb_waddr = idx;
    rb_wdata = b_new;
    mcmd.op  = MX_IDLE;
    mcmd.k   = sub[2:0] - 3'd1;
    mcmd.val = pass2 ? sm_q : rb_data;
    unique case (state)
      S_IDLE: begin
        if (in_accept && op_t'(operation) == OP_LOAD) begin
          rb_we    = 1'b1;
          rb_waddr = seed_index[SIZE_LOG2-1:0];
          rb_wdata = seed_word;
        end
      end
      S_I_START: mcmd.op = MX_GOLD;
      S_I_PRE: begin
        mcmd.op = MX_STEP;
        mcmd.k  = sub[2:0];
      end
      S_I_ADD: begin
        sm_raddr = sub_addr;
        rb_raddr = sub_addr;
        if (sub != 4'd0) mcmd.op = MX_ADD;
      end
      S_I_MIX: begin
        mcmd.op = MX_STEP;
        mcmd.k  = sub[2:0];
      end
      S_I_WR: begin
        sm_we    = 1'b1;
        sm_waddr = sub_addr;
        sm_wdata = v[sub[2:0]];
      end
      S_G_START: sm_raddr = idx;
      S_G_X:     sm_raddr = idx ^ HALF;
      S_G_J:     sm_raddr = x[SIZE_LOG2+1:2];
      S_G_Y:     sm_we    = 1'b1;
      S_G_R:     sm_raddr = y[2*SIZE_LOG2+1:SIZE_LOG2+2];
      S_G_B: begin
        rb_we    = 1'b1;
        sm_raddr = idx + SIZE_LOG2'(1);
      end
      S_N_RD:  rb_raddr = SIZE_LOG2'(words_left - (SIZE_LOG2 + 1)'(1));
      S_N_OUT: rb_raddr = words_left[SIZE_LOG2-1:0];
      default: sm_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm[sm_waddr] <= sm_wdata;
    sm_q <= sm[sm_raddr];
    if (rb_we) rb[rb_waddr] <= rb_wdata;
    rb_q  <= rb[rb_raddr];
    rb_qv <= rb_valid[rb_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb_valid <= '0;
    end else if (rb_we) begin
      rb_valid[rb_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seed_mode     <= 1'b0;
      accum_a       <= '0;
      accum_b       <= '0;
      round_counter <= '0;
      words_left    <= '0;
      out_valid     <= 1'b0;
      idx           <= '0;
      sub           <= '0;
      rep           <= '0;
      pass2         <= 1'b0;
      from_next     <= 1'b0;
    end else begin
      // S_N_OUT reloads the output register itself
      if (out_valid && !out_stall && state != S_N_OUT) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) seed_mode <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            priority case (op_t'(operation))
              OP_INIT: state <= S_I_START;
              OP_NEXT: begin
                from_next <= 1'b1;
                idx       <= '0;
                state     <= (words_left == '0) ? S_G_START : S_N_RD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_I_START: begin
          accum_a       <= '0;
          accum_b       <= '0;
          round_counter <= '0;
          sub           <= '0;
          rep           <= '0;
          pass2         <= 1'b0;
          from_next     <= 1'b0;
          idx           <= '0;
          state         <= S_I_PRE;
        end
        S_I_PRE: begin
          sub <= (sub == 4'd7) ? 4'd0 : sub + 4'd1;
          if (sub == 4'd7) begin
            rep <= rep + 2'd1;
            if (rep == 2'd3) state <= seed_mode ? S_I_ADD : S_I_MIX;
          end
        end
        S_I_ADD: begin
          if (sub == 4'd8) begin
            sub   <= '0;
            state <= S_I_MIX;
          end else begin
            sub <= sub + 4'd1;
          end
        end
        S_I_MIX: begin
          if (sub == 4'd7) begin
            sub   <= '0;
            state <= S_I_WR;
          end else begin
            sub <= sub + 4'd1;
          end
        end
        S_I_WR: begin
          if (sub == 4'd7) begin
            sub <= '0;
            if (idx == LAST_BLK) begin
              idx <= '0;
              if (seed_mode && !pass2) begin
                pass2 <= 1'b1;
                state <= S_I_ADD;
              end else begin
                state <= S_G_START;
              end
            end else begin
              idx   <= idx + SIZE_LOG2'(8);
              state <= seed_mode ? S_I_ADD : S_I_MIX;
            end
          end else begin
            sub <= sub + 4'd1;
          end
        end
        S_G_START: begin
          round_counter <= rc_inc;
          accum_b       <= accum_b + rc_inc;
          state         <= S_G_X;
        end
        S_G_X: begin
          x     <= sm_q;
          state <= S_G_J;
        end
        S_G_J: begin
          accum_a <= a_upd;
          state   <= S_G_Y;
        end
        S_G_Y: begin
          y     <= y_new;
          state <= S_G_R;
        end
        S_G_R: state <= S_G_B;
        S_G_B: begin
          accum_b <= b_new;
          if (idx == LAST_IDX) begin
            idx        <= '0;
            words_left <= FULL;
            state      <= from_next ? S_N_RD : S_IDLE;
          end else begin
            idx   <= idx + SIZE_LOG2'(1);
            state <= S_G_X;
          end
        end
        S_N_RD: begin
          words_left <= words_left - (SIZE_LOG2 + 1)'(1);
          state      <= S_N_OUT;
        end
        S_N_OUT: begin
          if (!out_valid || !out_stall) begin
            random_word <= rb_data;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ISAAC_ASSERT(a_words_bound, (words_left <= FULL), "words_left above buffer size")
  `ISAAC_ASSERT_NEXT(a_out_load, (state == S_N_OUT && !(out_valid && out_stall)), (out_valid && state == S_IDLE), "result not delivered to output")
  `ISAAC_ASSERT_NEXT(a_idle_accept, (in_accept && op_t'(operation) == OP_LOAD), (state == S_IDLE && rb_valid[$past(seed_index[SIZE_LOG2-1:0])]), "load item not stored")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import isaac_pkg::*;

  class isaac_scoreboard;
    logic [31:0] smem [256];
    logic [31:0] rbuf [256];
    logic [31:0] acc_a, acc_b, rounds;
    int unsigned words_left;
    bit          seed_mode;
    logic [31:0] pending_words [$];
    int          errors;
    int          results_seen;

    function new();
      foreach (smem[i]) begin
        smem[i] = '0;
        rbuf[i] = '0;
      end
      acc_a = '0;
      acc_b = '0;
      rounds = '0;
      words_left = 0;
      seed_mode = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function word8_t mix8(word8_t v);
      v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
      v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
      v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
      v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
      v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
      v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
      v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
      v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
      return v;
    endfunction

    function void refill();
      logic [31:0] a, b, x, y, mv;
      logic [7:0]  j;
      a = acc_a;
      rounds += 1;
      b = acc_b + rounds;
      for (int i = 0; i < 256; i++) begin
        j = 8'(i + 128);
        x = smem[i];
        case (i % 4)
          0: mv = a << 13;
          1: mv = a >> 6;
          2: mv = a << 2;
          default: mv = a >> 16;
        endcase
        a = (a ^ mv) + smem[j];
        y = smem[x[9:2]] + a + b;
        smem[i] = y;
        b = smem[y[17:10]] + x;
        rbuf[i] = b;
      end
      acc_a = a;
      acc_b = b;
    endfunction

    function void seed_state();
      word8_t v;
      acc_a = '0;
      acc_b = '0;
      rounds = '0;
      for (int k = 0; k < 8; k++) v[k] = GOLDEN;
      for (int k = 0; k < 4; k++) v = mix8(v);
      if (!seed_mode) begin
        for (int i = 0; i < 256; i += 8) begin
          v = mix8(v);
          for (int k = 0; k < 8; k++) smem[i + k] = v[k];
        end
      end else begin
        for (int i = 0; i < 256; i += 8) begin
          for (int k = 0; k < 8; k++) v[k] += rbuf[i + k];
          v = mix8(v);
          for (int k = 0; k < 8; k++) smem[i + k] = v[k];
        end
        // second pass folds in the first-pass state words
        for (int i = 0; i < 256; i += 8) begin
          for (int k = 0; k < 8; k++) v[k] += smem[i + k];
          v = mix8(v);
          for (int k = 0; k < 8; k++) smem[i + k] = v[k];
        end
      end
      refill();
      words_left = 256;
    endfunction

    function void note_request(op_t op, logic [7:0] idx, logic [31:0] word);
      case (op)
        OP_LOAD: rbuf[idx] = word;
        OP_INIT: seed_state();
        OP_NEXT: begin
          if (words_left == 0) begin
            refill();
            words_left = 256;
          end
          words_left--;
          pending_words.push_back(rbuf[words_left]);
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [31:0] actual);
      logic [31:0] want;
      results_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected random_word %h", actual);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (actual !== want) begin
        $error("random_word mismatch: expected %h actual %h", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  operation = OP_LOAD;
  logic [7:0]  seed_index = '0;
  logic [31:0] seed_word = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] random_word;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_data = 0;

  isaac_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int requests = 0;
  int inits = 0;

  isaac_random_generator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .seed_index(seed_index), .seed_word(seed_word),
    .out_valid(out_valid), .out_stall(out_stall), .random_word(random_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #40_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // receiver: random stall, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(random_word);
  end

  task automatic send(op_t op, logic [7:0] idx, logic [31:0] word);
    in_valid <= 1;
    operation <= op;
    seed_index <= idx;
    seed_word <= word;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, idx, word);
    requests++;
    if (op == OP_INIT) inits++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // called after reset or after drain; an initialize may still be running
  task automatic write_mode(bit m);
    repeat (4000) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.seed_mode = m;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 2) send(OP_INIT, 8'($urandom), $urandom);
    else if (r < 4) send(OP_NONE, 8'($urandom), $urandom);
    else if (r < 30) send(OP_LOAD, 8'($urandom), $urandom);
    else send(OP_NEXT, 8'($urandom), $urandom);
  endtask

  task automatic run_phase(bit m, int sidle, int rstall, int count);
    drain();
    write_mode(m);
    send_idle_pct = sidle;
    stall_pct = rstall;
    // full seed load followed by initialize, then random traffic
    for (int i = 0; i < 256; i++) send(OP_LOAD, 8'(i), $urandom);
    send(OP_INIT, 8'($urandom), $urandom);
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) hold_req = 400;
      if (n == count / 2) drain();
      random_item();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_mode(0);
    // directed: field extremes, every operation, index wrap edges
    send(OP_LOAD, 8'h00, 32'h0000_0000);
    send(OP_LOAD, 8'hff, 32'hffff_ffff);
    send(OP_NONE, 8'hff, 32'hffff_ffff);
    send(OP_INIT, 8'h00, 32'h0);
    repeat (6) send(OP_NEXT, 8'h00, 32'h0);
    send(OP_INIT, 8'hff, 32'hffff_ffff);
    repeat (2) send(OP_NEXT, 8'hff, 32'hffff_ffff);
    drain();
    write_mode(1);
    send(OP_LOAD, 8'h00, 32'hffff_ffff);
    send(OP_LOAD, 8'hff, 32'h0000_0000);
    send(OP_LOAD, 8'h80, 32'h8000_0001);
    send(OP_INIT, 8'h00, 32'h0);
    repeat (4) send(OP_NEXT, 8'h00, 32'h0);
    send(OP_NONE, 8'h00, 32'h0);

    run_phase(1, 7, 87, 380);
    run_phase(0, 87, 7, 380);
    run_phase(1, 0, 0, 380);

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d initializations, %0d words checked, both seed modes",
             requests, inits, sb.results_seen);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/isaac_pkg.sv
src/isaac_mix.sv
src/isaac_random_generator.sv
dv/tb_top.sv
